### hdl/piece_attack_set_generator_assert.svh
// assertion macros for the piece attack set generator
// expects signals clk and rst_n in the scope where a macro is used
`ifndef PIECE_ATTACK_SET_GENERATOR_ASSERT_SVH
`define PIECE_ATTACK_SET_GENERATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define PASG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PASG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pasg_pkg.sv
// shared types, constants and attack functions for the piece attack set generator
// no dependencies
package pasg_pkg;

    localparam int BOARD_DIM = 8;
    localparam int MAX_STEP  = 7;
    localparam int JUMP_CNT  = 8;

    typedef enum logic [2:0] {
        KIND_ROOK   = 3'd0,
        KIND_BISHOP = 3'd1,
        KIND_QUEEN  = 3'd2,
        KIND_KNIGHT = 3'd3,
        KIND_KING   = 3'd4
    } piece_kind_t;

    // signed board coordinate with room for off-board excursions
    typedef logic signed [4:0] coord_t;

    localparam coord_t KNIGHT_DF [JUMP_CNT] =
        '{5'sd1, -5'sd1, 5'sd1, -5'sd1, 5'sd2, -5'sd2, 5'sd2, -5'sd2};
    localparam coord_t KNIGHT_DR [JUMP_CNT] =
        '{5'sd2, 5'sd2, -5'sd2, -5'sd2, 5'sd1, 5'sd1, -5'sd1, -5'sd1};
    localparam coord_t KING_DF [JUMP_CNT] =
        '{-5'sd1, -5'sd1, -5'sd1, 5'sd0, 5'sd0, 5'sd1, 5'sd1, 5'sd1};
    localparam coord_t KING_DR [JUMP_CNT] =
        '{-5'sd1, 5'sd0, 5'sd1, -5'sd1, 5'sd1, -5'sd1, 5'sd0, 5'sd1};

    function automatic logic on_board(input coord_t cf, input coord_t cr);
        return (cf[4:3] == 2'b00) && (cr[4:3] == 2'b00);
    endfunction

    // walk one ray, the first occupied square is included and ends it
    function automatic logic [63:0] ray_scan(input logic [5:0] sq, input coord_t df,
                                             input coord_t dr, input logic [63:0] occ);
        coord_t      cf;
        coord_t      cr;
        logic        open;
        logic [5:0]  idx;
        logic [63:0] acc;
        cf   = {2'b00, sq[2:0]};
        cr   = {2'b00, sq[5:3]};
        open = 1'b1;
        acc  = '0;
        for (int k = 0; k < MAX_STEP; k++)
        begin
            cf  = cf + df;
            cr  = cr + dr;
            idx = {cr[2:0], cf[2:0]};
            if (open && on_board(cf, cr))
            begin
                acc[idx] = 1'b1;
                if (occ[idx])
                    open = 1'b0;
            end
            else
                open = 1'b0;
        end
        return acc;
    endfunction

    function automatic logic [63:0] straight_set(input logic [5:0] sq, input logic [63:0] occ);
        return ray_scan(sq, 5'sd0, 5'sd1, occ) | ray_scan(sq, 5'sd0, -5'sd1, occ)
             | ray_scan(sq, 5'sd1, 5'sd0, occ) | ray_scan(sq, -5'sd1, 5'sd0, occ);
    endfunction

    function automatic logic [63:0] diagonal_set(input logic [5:0] sq, input logic [63:0] occ);
        return ray_scan(sq, 5'sd1, 5'sd1, occ) | ray_scan(sq, -5'sd1, 5'sd1, occ)
             | ray_scan(sq, 5'sd1, -5'sd1, occ) | ray_scan(sq, -5'sd1, -5'sd1, occ);
    endfunction

    // fixed offsets, occupancy plays no part
    function automatic logic [63:0] jump_set(input logic [5:0] sq, input logic is_king);
        coord_t      cf;
        coord_t      cr;
        logic [5:0]  idx;
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < JUMP_CNT; i++)
        begin
            cf  = coord_t'({2'b00, sq[2:0]}) + (is_king ? KING_DF[i] : KNIGHT_DF[i]);
            cr  = coord_t'({2'b00, sq[5:3]}) + (is_king ? KING_DR[i] : KNIGHT_DR[i]);
            idx = {cr[2:0], cf[2:0]};
            if (on_board(cf, cr))
                acc[idx] = 1'b1;
        end
        return acc;
    endfunction

endpackage

### hdl/pasg_req_if.sv
// request channel: piece kind, square and occupancy with valid/ready
// uses no package
interface pasg_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [5:0]  square;
    logic [63:0] occupancy;

    modport source (output valid, req_type, square, occupancy, input ready);
    modport sink   (input valid, req_type, square, occupancy, output ready);
endinterface

### hdl/pasg_res_if.sv
// result channel: attacked square set with valid/ready
// uses no package
interface pasg_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] attack_bits;

    modport source (output valid, attack_bits, input ready);
    modport sink   (input valid, attack_bits, output ready);
endinterface

### hdl/piece_attack_set_generator.sv
// piece attack set generator: input register, ray scan logic, result register
// depends on pasg_pkg, pasg_req_if, pasg_res_if and piece_attack_set_generator_assert.svh
//
// One request item in, one attack set out. The block takes a new item every cycle
// unless the sink stalls it, as told below. In order: the item is captured in an
// input register, the eight rook and bishop rays (each up to seven squares) and the
// knight and king jump sets are formed in one combinational pass, and the selected
// set lands in the result register. While the result waits for the sink, the input
// register still takes one more item; after that ready drops until the sink takes
// the result. Piece kinds 5 to 7 give an empty set, and the piece's own square is
// never part of a result.
`include "piece_attack_set_generator_assert.svh"

module piece_attack_set_generator
    import pasg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pasg_req_if.sink      req,
    pasg_res_if.source    res
);

    logic        in_valid_reg;
    logic [2:0]  kind_reg;
    logic [5:0]  square_reg;
    logic [63:0] occ_reg;

    logic        out_valid_reg;
    logic [63:0] attack_reg;
    logic [63:0] attack_next;

    logic        out_free;
    logic        stage_move;
    logic        in_take;

    assign out_free   = !out_valid_reg || res.ready;
    assign stage_move = in_valid_reg && out_free;
    assign req.ready  = !in_valid_reg || out_free;
    assign in_take    = req.valid && req.ready;

    always_comb
    begin
        unique case (kind_reg)
            KIND_ROOK:   attack_next = straight_set(square_reg, occ_reg);
            KIND_BISHOP: attack_next = diagonal_set(square_reg, occ_reg);
            KIND_QUEEN:  attack_next = straight_set(square_reg, occ_reg)
                                     | diagonal_set(square_reg, occ_reg);
            KIND_KNIGHT: attack_next = jump_set(square_reg, 1'b0);
            KIND_KING:   attack_next = jump_set(square_reg, 1'b1);
            default:     attack_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= req.req_type;
            square_reg <= req.square;
            occ_reg    <= req.occupancy;
        end
        if (stage_move)
            attack_reg <= attack_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.attack_bits = attack_reg;

    `PASG_ASSERT_NEXT(a_move_fills_out, stage_move, out_valid_reg,
        "item in input register lost on its way to the result register")
    `PASG_ASSERT_NOW(a_full_stall_blocks, in_valid_reg && out_valid_reg && !res.ready,
        !req.ready, "new item accepted while both registers are held")
    `PASG_ASSERT_NOW(a_own_square_clear, in_valid_reg, !attack_next[square_reg],
        "attack set contains the piece's own square")
    `PASG_ASSERT_NOW(a_bad_kind_empty, in_valid_reg && (kind_reg > KIND_KING),
        attack_next == '0, "undefined piece kind gives a nonempty set")

endmodule

### sim/testbench.sv
// self-checking testbench for the piece attack set generator
// depends on pasg_pkg, pasg_req_if, pasg_res_if and piece_attack_set_generator from hdl
// directed corner queries, then random queries under four flow-control mixes

module testbench;
    import pasg_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 450;

    // holds the attack sets still owed by the block, oldest first
    class attack_scoreboard;
        logic [63:0] owed_sets[$];
        int          mismatches;
        int          results_checked;

        function new();
            mismatches      = 0;
            results_checked = 0;
        endfunction

        // squares along one ray, first occupied square included
        function logic [63:0] ray_reach(int fl, int rk, int dfl, int drk, logic [63:0] occ);
            logic [63:0] reach;
            int          f;
            int          r;
            logic        blocked;
            reach   = '0;
            blocked = 1'b0;
            f       = fl + dfl;
            r       = rk + drk;
            while (!blocked && f >= 0 && f < 8 && r >= 0 && r < 8)
            begin
                reach[r * 8 + f] = 1'b1;
                blocked          = occ[r * 8 + f];
                f                = f + dfl;
                r                = r + drk;
            end
            return reach;
        endfunction

        // knight: |df|*|dr| == 2, king: chebyshev distance one
        function logic [63:0] hop_reach(int fl, int rk, logic is_king);
            logic [63:0] reach;
            int          adf;
            int          adr;
            reach = '0;
            for (int df = -2; df <= 2; df++)
            begin
                for (int dr = -2; dr <= 2; dr++)
                begin
                    adf = (df < 0) ? -df : df;
                    adr = (dr < 0) ? -dr : dr;
                    if ((is_king ? (adf <= 1 && adr <= 1 && adf + adr > 0) : (adf * adr == 2))
                        && fl + df >= 0 && fl + df < 8 && rk + dr >= 0 && rk + dr < 8)
                        reach[(rk + dr) * 8 + fl + df] = 1'b1;
                end
            end
            return reach;
        endfunction

        function logic [63:0] attack_set(logic [2:0] kind, logic [5:0] sq, logic [63:0] occ);
            int          fl;
            int          rk;
            logic [63:0] lines;
            logic [63:0] diags;
            fl    = int'(sq[2:0]);
            rk    = int'(sq[5:3]);
            lines = ray_reach(fl, rk, 0, 1, occ) | ray_reach(fl, rk, 0, -1, occ)
                  | ray_reach(fl, rk, 1, 0, occ) | ray_reach(fl, rk, -1, 0, occ);
            diags = ray_reach(fl, rk, 1, 1, occ) | ray_reach(fl, rk, -1, 1, occ)
                  | ray_reach(fl, rk, 1, -1, occ) | ray_reach(fl, rk, -1, -1, occ);
            case (kind)
                KIND_ROOK:   return lines;
                KIND_BISHOP: return diags;
                KIND_QUEEN:  return lines | diags;
                KIND_KNIGHT: return hop_reach(fl, rk, 1'b0);
                KIND_KING:   return hop_reach(fl, rk, 1'b1);
                default:     return '0;
            endcase
        endfunction

        function void note_request(logic [2:0] kind, logic [5:0] sq, logic [63:0] occ);
            owed_sets.push_back(attack_set(kind, sq, occ));
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (owed_sets.size() == 0)
            begin
                $error("attack_bits: expected no item, actual %016h", got);
                mismatches++;
                return;
            end
            want = owed_sets.pop_front();
            results_checked++;
            if (got !== want)
            begin
                $error("attack_bits: expected %016h, actual %016h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pasg_req_if req_ch ();
    pasg_res_if res_ch ();

    piece_attack_set_generator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    attack_scoreboard board_check;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               requests_taken;
    int               quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink side: random back-pressure
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            board_check.note_request(req_ch.req_type, req_ch.square, req_ch.occupancy);
            requests_taken++;
        end
        if (rst_n && res_ch.valid && res_ch.ready)
            board_check.check_result(res_ch.attack_bits);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] kind, input logic [5:0] sq,
                                input logic [63:0] occ);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.square    <= sq;
        req_ch.occupancy <= occ;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct);
        logic [2:0]  kind;
        logic [63:0] occ;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items)
        begin
            // undefined kinds only now and then
            if ($urandom_range(15) == 0)
                kind = 3'($urandom_range(7, 5));
            else
                kind = 3'($urandom_range(4, 0));
            occ = {$urandom, $urandom};
            case ($urandom_range(9))
                0, 1, 2: occ = occ & {$urandom, $urandom} & {$urandom, $urandom};
                6, 7:    occ = occ | {$urandom, $urandom};
                8:       occ = '0;
                9:       occ = '1;
                default: ;
            endcase
            send_request(kind, 6'($urandom_range(63)), occ);
        end
    endtask

    initial
    begin
        board_check      = new();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        rst_n            = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= '0;
        req_ch.square    <= '0;
        req_ch.occupancy <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // corners, center, empty and full boards, own square set in occupancy
        send_request(KIND_ROOK,   6'd0,  64'h0);
        send_request(KIND_ROOK,   6'd63, '1);
        send_request(KIND_ROOK,   6'd27, 64'h0000_0000_0800_0000);
        send_request(KIND_ROOK,   6'd27, 64'h0000_0008_1408_0000);
        send_request(KIND_BISHOP, 6'd7,  64'h0);
        send_request(KIND_BISHOP, 6'd27, '1);
        send_request(KIND_BISHOP, 6'd9,  64'h8000_0000_0000_0000);
        send_request(KIND_BISHOP, 6'd56, 64'h0000_0000_0000_0080);
        send_request(KIND_QUEEN,  6'd0,  64'h0);
        send_request(KIND_QUEEN,  6'd63, '1);
        send_request(KIND_QUEEN,  6'd36, 64'h5555_5555_5555_5555);
        send_request(KIND_QUEEN,  6'd36, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(KIND_KNIGHT, 6'd0,  '1);
        send_request(KIND_KNIGHT, 6'd63, 64'h0);
        send_request(KIND_KNIGHT, 6'd27, '1);
        send_request(KIND_KNIGHT, 6'd15, 64'h0);
        send_request(KIND_KING,   6'd0,  64'h0);
        send_request(KIND_KING,   6'd63, '1);
        send_request(KIND_KING,   6'd36, 64'h0);
        send_request(KIND_KING,   6'd56, '1);
        send_request(3'd5,        6'd27, '1);
        send_request(3'd6,        6'd0,  64'h0);
        send_request(3'd7,        6'd63, 64'hffff_0000_ffff_0000);

        run_random_phase(PHASE_ITEMS, 0, 0);
        run_random_phase(PHASE_ITEMS, 67, 0);
        run_random_phase(PHASE_ITEMS, 0, 67);
        run_random_phase(PHASE_ITEMS, 16, 16);
        req_ch.valid <= 1'b0;

        while (board_check.owed_sets.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("covered %0d attack queries: all five piece kinds, undefined kinds, edge squares",
                 requests_taken);
        $display("and empty to full boards; %0d results checked across four idle/stall mixes",
                 board_check.results_checked);
        if (board_check.mismatches == 0 && board_check.owed_sets.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/pasg_pkg.sv
hdl/pasg_req_if.sv
hdl/pasg_res_if.sv
hdl/piece_attack_set_generator.sv
sim/testbench.sv
